@@ src/mcs_pkg.sv @@
package mcs_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int MAX_PIXELS = 4096;
	localparam int ADDR_W     = $clog2(MAX_PIXELS);
	localparam int CNT_W      = ADDR_W + 1;
	localparam int PIX_W      = 8;
	localparam int SPAN_W     = SAMPLE_W;
	localparam int DIV_W      = SPAN_W + 1;
	localparam int DVD_W      = CNT_W;
	localparam int ITER_W     = $clog2(DVD_W + 1);
	localparam int PROD_W     = SPAN_W + PIX_W;
	localparam int COLS_RESET = 64;

	// Iteration counts of the dividers.
	localparam logic [ITER_W-1:0] ITER_IDX = ITER_W'(DVD_W);
	localparam logic [ITER_W-1:0] ITER_PIX = ITER_W'(PIX_W);

	// Configuration register indexes.
	localparam logic CFG_TRANSPOSE = 1'b0;
	localparam logic CFG_COLUMNS   = 1'b1;

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_TOP = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_BOT = {1'b1, {(SAMPLE_W-1){1'b0}}};

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic emit;
		logic t1_start;
		logic t2_start;
		logic addr_tr;
		logic prep;
		logic band_start;
		logic fire;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic svc_ok;
		logic tr_ok;
		logic div_done;
		logic rem_zero;
	} stat_t;

	typedef struct packed {
		logic [SPAN_W-1:0] off;
		logic [SPAN_W-1:0] span;
	} band_t;

	// Offset and span of one band; a flat band or a sample below the minimum
	// yields a zero offset over a unit span so that the quotient is zero.
	function automatic band_t band_prep(input logic signed [SAMPLE_W-1:0] s,
			input logic signed [SAMPLE_W-1:0] lo, input logic signed [SAMPLE_W-1:0] hi);
		logic signed [SAMPLE_W:0] d_span;
		logic signed [SAMPLE_W:0] d_off;
		band_t r;
		d_span = {hi[SAMPLE_W-1], hi} - {lo[SAMPLE_W-1], lo};
		d_off  = {s[SAMPLE_W-1], s} - {lo[SAMPLE_W-1], lo};
		if (hi <= lo || s < lo) begin
			r.off  = '0;
			r.span = SPAN_W'(1);
		end else begin
			r.span = d_span[SPAN_W-1:0];
			r.off  = (d_off > d_span) ? d_span[SPAN_W-1:0] : d_off[SPAN_W-1:0];
		end
		return r;
	endfunction

endpackage

@@ src/mcs_div.sv @@
module mcs_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [mcs_pkg::DIV_W-1:0]       rem_init,
	input  logic [mcs_pkg::DVD_W-1:0]       dvd,
	input  logic [mcs_pkg::DIV_W-1:0]       divisor,
	input  logic [mcs_pkg::ITER_W-1:0]      iters,
	output logic                            done,
	output logic [mcs_pkg::DVD_W-1:0]       quo,
	output logic [mcs_pkg::DIV_W-1:0]       rem
);

	localparam logic [mcs_pkg::ITER_W-1:0] ITER_ONE = mcs_pkg::ITER_W'(1);

	logic                          busy_q;
	logic                          done_q;
	logic [mcs_pkg::ITER_W-1:0]    n_q;
	logic [mcs_pkg::DIV_W-1:0]     rem_q;
	logic [mcs_pkg::DVD_W-1:0]     dvd_q;
	logic [mcs_pkg::DVD_W-1:0]     quo_q;
	logic [mcs_pkg::DIV_W-1:0]     divisor_q;
	logic [mcs_pkg::DIV_W:0]       trial;
	logic [mcs_pkg::DIV_W:0]       diff;
	logic                          ge;

	// One restoring step: bring down the next dividend bit and try the divisor.
	assign trial = {rem_q, dvd_q[mcs_pkg::DVD_W-1]};
	assign diff  = trial - {1'b0, divisor_q};
	assign ge    = (trial >= {1'b0, divisor_q});

	// Control state of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			n_q    <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			n_q    <= iters;
		end else if (busy_q) begin
			n_q <= n_q - ITER_ONE;
			if (n_q == ITER_ONE) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Partial remainder, dividend and quotient shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q     <= rem_init;
			dvd_q     <= dvd;
			quo_q     <= '0;
			divisor_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[mcs_pkg::DIV_W-1:0] : trial[mcs_pkg::DIV_W-1:0];
			dvd_q <= {dvd_q[mcs_pkg::DVD_W-2:0], 1'b0};
			quo_q <= {quo_q[mcs_pkg::DVD_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

@@ src/mcs_dp.sv @@
module mcs_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  mcs_pkg::cmd_t                        cmd,
	output mcs_pkg::stat_t                       stat,
	input  logic                                 cfg_valid,
	input  logic                                 cfg_index,
	input  logic [mcs_pkg::CNT_W-1:0]            cfg_data,
	input  logic signed [mcs_pkg::SAMPLE_W-1:0]  sample_red,
	input  logic signed [mcs_pkg::SAMPLE_W-1:0]  sample_green,
	input  logic signed [mcs_pkg::SAMPLE_W-1:0]  sample_blue,
	input  logic                                 frame_end,
	output logic                                 strobe,
	output logic [mcs_pkg::PIX_W-1:0]            pixel_red,
	output logic [mcs_pkg::PIX_W-1:0]            pixel_green,
	output logic [mcs_pkg::PIX_W-1:0]            pixel_blue,
	output logic                                 final_pixel
);

	localparam int SW = mcs_pkg::SAMPLE_W;
	localparam int CW = mcs_pkg::CNT_W;
	localparam int AW = mcs_pkg::ADDR_W;

	logic                        transpose_q;
	logic [CW-1:0]               cols_q;
	logic signed [SW-1:0]        min_q [3];
	logic signed [SW-1:0]        max_q [3];
	logic [CW-1:0]               cnt_q;
	logic [CW-1:0]               pos_q;
	logic                        ready_q;
	logic [CW-1:0]               p_q;
	logic [AW-1:0]               addr_q;
	logic [3*SW-1:0]             mem [mcs_pkg::MAX_PIXELS];
	logic [3*SW-1:0]             rd_q;
	mcs_pkg::band_t              band_q [3];
	logic                        strobe_q;
	logic [mcs_pkg::PIX_W-1:0]   pix_q [3];
	logic                        final_q;

	logic [CW-1:0]               cnt_eff;
	logic                        store_ok;
	logic signed [SW-1:0]        smp [3];
	logic signed [SW-1:0]        min_eff [3];
	logic signed [SW-1:0]        max_eff [3];
	logic [CW-1:0]               idx;
	logic [2*CW-1:0]             tr_prod;
	logic [AW-1:0]               tr_addr;

	logic                        div_start;
	logic [mcs_pkg::DIV_W-1:0]   d_rem_init [3];
	logic [mcs_pkg::DVD_W-1:0]   d_dvd [3];
	logic [mcs_pkg::DIV_W-1:0]   d_divisor [3];
	logic [mcs_pkg::ITER_W-1:0]  d_iters;
	logic                        d_done [3];
	logic [mcs_pkg::DVD_W-1:0]   d_quo [3];
	logic [mcs_pkg::DIV_W-1:0]   d_rem [3];
	logic [mcs_pkg::PROD_W-1:0]  prod [3];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			transpose_q <= 1'b0;
			cols_q      <= CW'(mcs_pkg::COLS_RESET);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				mcs_pkg::CFG_TRANSPOSE: transpose_q <= cfg_data[0];
				mcs_pkg::CFG_COLUMNS:   cols_q      <= cfg_data;
				default:                cols_q      <= cols_q;
			endcase
		end
	end

	// A load after a closed frame starts over from an empty frame.
	assign smp[0]   = sample_red;
	assign smp[1]   = sample_green;
	assign smp[2]   = sample_blue;
	assign cnt_eff  = ready_q ? '0 : cnt_q;
	assign store_ok = (cnt_eff < CW'(mcs_pkg::MAX_PIXELS));

	always_comb begin
		for (int b = 0; b < 3; b++) begin
			min_eff[b] = ready_q ? mcs_pkg::SAMPLE_TOP : min_q[b];
			max_eff[b] = ready_q ? mcs_pkg::SAMPLE_BOT : max_q[b];
		end
	end

	// Emit position, wrapped to zero when past the loaded frame.
	assign idx = (pos_q >= cnt_q) ? '0 : pos_q;

	// Transposed address from the remainder and quotient of position by rows.
	assign tr_prod = d_rem[0][CW-1:0] * cols_q;
	assign tr_addr = tr_prod[AW-1:0] + d_quo[0][AW-1:0];

	// Frame statistics, counters and the output strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < 3; b++) begin
				min_q[b] <= mcs_pkg::SAMPLE_TOP;
				max_q[b] <= mcs_pkg::SAMPLE_BOT;
			end
			cnt_q    <= '0;
			pos_q    <= '0;
			ready_q  <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.fire;
			if (cmd.load) begin
				for (int b = 0; b < 3; b++) begin
					min_q[b] <= (store_ok && smp[b] < min_eff[b]) ? smp[b] : min_eff[b];
					max_q[b] <= (store_ok && smp[b] > max_eff[b]) ? smp[b] : max_eff[b];
				end
				cnt_q <= store_ok ? cnt_eff + CW'(1) : cnt_eff;
				if (frame_end && (store_ok || cnt_eff != '0)) begin
					ready_q <= 1'b1;
					pos_q   <= '0;
				end else begin
					ready_q <= 1'b0;
					if (ready_q) begin
						pos_q <= '0;
					end
				end
			end
			if (cmd.fire) begin
				pos_q <= (p_q == cnt_q - CW'(1)) ? '0 : p_q + CW'(1);
			end
		end
	end

	// Sample store write, and the registered read of one triple.
	always_ff @(posedge clk) begin
		if (cmd.load && store_ok) begin
			mem[cnt_eff[AW-1:0]] <= {smp[2], smp[1], smp[0]};
		end
		rd_q <= mem[addr_q];
	end

	// Emit bookkeeping, band preparation and pixel capture.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			p_q    <= idx;
			addr_q <= idx[AW-1:0];
		end
		if (cmd.addr_tr) begin
			addr_q <= tr_addr;
		end
		if (cmd.prep) begin
			for (int b = 0; b < 3; b++) begin
				band_q[b] <= mcs_pkg::band_prep(rd_q[b*SW +: SW], min_q[b], max_q[b]);
			end
		end
		if (cmd.fire) begin
			for (int b = 0; b < 3; b++) begin
				pix_q[b] <= d_quo[b][mcs_pkg::PIX_W-1:0];
			end
			final_q <= (p_q == cnt_q - CW'(1));
		end
	end

	// Divider operands: band zero also serves the two index divisions.
	assign div_start = cmd.t1_start | cmd.t2_start | cmd.band_start;
	assign d_iters   = cmd.band_start ? mcs_pkg::ITER_PIX : mcs_pkg::ITER_IDX;

	always_comb begin
		for (int b = 0; b < 3; b++) begin
			prod[b]       = {band_q[b].off, {mcs_pkg::PIX_W{1'b0}}}
				- mcs_pkg::PROD_W'(band_q[b].off);
			d_rem_init[b] = mcs_pkg::DIV_W'(prod[b][mcs_pkg::PROD_W-1:mcs_pkg::PIX_W]);
			d_dvd[b]      = {prod[b][mcs_pkg::PIX_W-1:0],
				{(mcs_pkg::DVD_W-mcs_pkg::PIX_W){1'b0}}};
			d_divisor[b]  = mcs_pkg::DIV_W'(band_q[b].span);
		end
		if (cmd.t1_start) begin
			d_rem_init[0] = '0;
			d_dvd[0]      = cnt_q;
			d_divisor[0]  = mcs_pkg::DIV_W'(cols_q);
		end else if (cmd.t2_start) begin
			d_rem_init[0] = '0;
			d_dvd[0]      = p_q;
			d_divisor[0]  = mcs_pkg::DIV_W'(d_quo[0]);
		end
	end

	for (genvar g = 0; g < 3; g++) begin : g_div
		mcs_div u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.start    (div_start),
			.rem_init (d_rem_init[g]),
			.dvd      (d_dvd[g]),
			.divisor  (d_divisor[g]),
			.iters    (d_iters),
			.done     (d_done[g]),
			.quo      (d_quo[g]),
			.rem      (d_rem[g])
		);
	end

	// Status toward the controller.
	assign stat.svc_ok   = ready_q && (cnt_q != '0);
	assign stat.tr_ok    = transpose_q && (cols_q != '0) && (cols_q <= cnt_q);
	assign stat.div_done = d_done[0] & d_done[1] & d_done[2] | (d_done[0] & ~cmd.band_start
		& ~d_done[1] & ~d_done[2]);
	assign stat.rem_zero = (d_rem[0] == '0);

	assign strobe      = strobe_q;
	assign pixel_red   = pix_q[0];
	assign pixel_green = pix_q[1];
	assign pixel_blue  = pix_q[2];
	assign final_pixel = final_q;

endmodule

@@ src/mcs_ctrl.sv @@
module mcs_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            kind,
	input  mcs_pkg::stat_t  stat,
	output mcs_pkg::cmd_t   cmd,
	output logic            busy
);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_TDIV1  = 7'b0000010,
		ST_TDIV2  = 7'b0000100,
		ST_RD     = 7'b0001000,
		ST_PREP   = 7'b0010000,
		ST_BSTART = 7'b0100000,
		ST_BDIV   = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start && !kind) begin
					cmd.load = 1'b1;
				end else if (start && stat.svc_ok) begin
					cmd.emit = 1'b1;
					if (stat.tr_ok) begin
						cmd.t1_start = 1'b1;
						state_d      = ST_TDIV1;
					end else begin
						state_d = ST_RD;
					end
				end
			end
			ST_TDIV1: begin
				if (stat.div_done) begin
					if (stat.rem_zero) begin
						cmd.t2_start = 1'b1;
						state_d      = ST_TDIV2;
					end else begin
						state_d = ST_RD;
					end
				end
			end
			ST_TDIV2: begin
				if (stat.div_done) begin
					cmd.addr_tr = 1'b1;
					state_d     = ST_RD;
				end
			end
			ST_RD: begin
				state_d = ST_PREP;
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ST_BSTART;
			end
			ST_BSTART: begin
				cmd.band_start = 1'b1;
				state_d        = ST_BDIV;
			end
			ST_BDIV: begin
				if (stat.div_done) begin
					cmd.fire = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

@@ src/minmax_contrast_stretch_rgb.sv @@
// Load words leave busy low; emit words with no closed frame are dropped.
// An emitted pixel's strobe is registered from the band divisions; when transposed, index divisions
// come first, the second skipped when the column count does not divide the frame; it lasts one cycle.
// Three radix-2 dividers, one per band, take 8 steps; band zero also runs 13-step index divisions.
// A new word is taken only while busy is low, after the previous pixel; the receiver cannot stall.
// Asynchronous active-low reset empties the frame, clears the counters and returns the configuration to its defaults.
module minmax_contrast_stretch_rgb (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 kind,
	input  logic signed [mcs_pkg::SAMPLE_W-1:0]  sample_red,
	input  logic signed [mcs_pkg::SAMPLE_W-1:0]  sample_green,
	input  logic signed [mcs_pkg::SAMPLE_W-1:0]  sample_blue,
	input  logic                                 frame_end,
	output logic                                 strobe,
	output logic [mcs_pkg::PIX_W-1:0]            pixel_red,
	output logic [mcs_pkg::PIX_W-1:0]            pixel_green,
	output logic [mcs_pkg::PIX_W-1:0]            pixel_blue,
	output logic                                 final_pixel,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic                                 cfg_index,
	input  logic [mcs_pkg::CNT_W-1:0]            cfg_data
);

	mcs_pkg::cmd_t  cmd;
	mcs_pkg::stat_t stat;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	mcs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (kind),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	mcs_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_red   (sample_red),
		.sample_green (sample_green),
		.sample_blue  (sample_blue),
		.frame_end    (frame_end),
		.strobe       (strobe),
		.pixel_red    (pixel_red),
		.pixel_green  (pixel_green),
		.pixel_blue   (pixel_blue),
		.final_pixel  (final_pixel)
	);

endmodule

@@ src/mcs_chk.sv @@
module mcs_chk (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic kind,
	input logic strobe
);

	// Pixels are far apart, so a strobe is never held high.
	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !strobe) else $error("strobe held two cycles");

	// A load word completes in its accept cycle.
	a_load_fast: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !kind) |=> !busy) else $error("busy after load");

	// A pixel is delivered only once the block is idle again.
	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !busy) else $error("strobe while busy");

	// No pixel comes out in the cycle after an emit is taken.
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && kind) |=> !strobe) else $error("pixel too early");

endmodule

bind minmax_contrast_stretch_rgb mcs_chk u_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.kind   (kind),
	.strobe (strobe)
);

@@ tb/sv/minmax_contrast_stretch_rgb_tb.sv @@
module minmax_contrast_stretch_rgb_tb;
	import mcs_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 60;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_EMIT = 1'b1;

	typedef struct {
		logic                       kind;
		logic signed [SAMPLE_W-1:0] red;
		logic signed [SAMPLE_W-1:0] green;
		logic signed [SAMPLE_W-1:0] blue;
		logic                       frame_end;
	} word_t;

	typedef struct {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
		logic             last;
	} pixel_t;

	logic                       clk;
	logic                       arst_n;
	logic                       start;
	logic                       busy;
	logic                       kind;
	logic signed [SAMPLE_W-1:0] sample_red;
	logic signed [SAMPLE_W-1:0] sample_green;
	logic signed [SAMPLE_W-1:0] sample_blue;
	logic                       frame_end;
	logic                       strobe;
	logic [PIX_W-1:0]           pixel_red;
	logic [PIX_W-1:0]           pixel_green;
	logic [PIX_W-1:0]           pixel_blue;
	logic                       final_pixel;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic                       cfg_index;
	logic [CNT_W-1:0]           cfg_data;

	minmax_contrast_stretch_rgb u_top (.*);

	// Clock generation.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Frame model kept alongside the block.
	logic signed [SAMPLE_W-1:0] frame_store [MAX_PIXELS][3];
	longint                     band_lo [3];
	longint                     band_hi [3];
	int unsigned                frame_count;
	int unsigned                emit_index;
	bit                         frame_closed;
	bit                         mode_transpose;
	int unsigned                mode_columns;

	word_t       pending_words [$];
	pixel_t      expected_pixels [$];
	word_t       current_word;
	int          sender_idle_pct;
	int          error_count;
	int          words_accepted;
	int          pixels_checked;
	int          quiet_cycles;

	function automatic void restart_frame();
		for (int b = 0; b < 3; b++) begin
			band_lo[b] = 32767;
			band_hi[b] = -32768;
		end
		frame_count  = 0;
		emit_index   = 0;
		frame_closed = 0;
	endfunction

	function automatic logic [PIX_W-1:0] stretch_band(input longint s, input int b);
		longint span;
		longint off;
		if (band_hi[b] <= band_lo[b] || s < band_lo[b])
			return '0;
		span = band_hi[b] - band_lo[b];
		off  = s - band_lo[b];
		if (off > span)
			off = span;
		return PIX_W'((255 * off) / span);
	endfunction

	// Apply one accepted word to the frame model; emits may queue a pixel.
	function automatic void track_word(input word_t w);
		longint      s [3];
		int unsigned pos;
		int unsigned addr;
		int unsigned rows;
		pixel_t      p;
		s[0] = w.red;
		s[1] = w.green;
		s[2] = w.blue;
		if (w.kind == KIND_LOAD) begin
			if (frame_closed)
				restart_frame();
			if (frame_count < MAX_PIXELS) begin
				for (int b = 0; b < 3; b++) begin
					frame_store[frame_count][b] = s[b];
					if (s[b] < band_lo[b]) band_lo[b] = s[b];
					if (s[b] > band_hi[b]) band_hi[b] = s[b];
				end
				frame_count++;
			end
			if (w.frame_end && frame_count > 0) begin
				frame_closed = 1;
				emit_index   = 0;
			end
		end else if (frame_closed && frame_count > 0) begin
			pos = (emit_index >= frame_count) ? 0 : emit_index;
			addr = pos;
			if (mode_transpose && mode_columns >= 1 && mode_columns <= frame_count &&
					frame_count % mode_columns == 0) begin
				rows = frame_count / mode_columns;
				addr = (pos % rows) * mode_columns + pos / rows;
			end
			if (addr >= MAX_PIXELS)
				addr = 0;
			p.red   = stretch_band(frame_store[addr][0], 0);
			p.green = stretch_band(frame_store[addr][1], 1);
			p.blue  = stretch_band(frame_store[addr][2], 2);
			p.last  = (pos == frame_count - 1);
			emit_index = p.last ? 0 : pos + 1;
			expected_pixels.push_back(p);
		end
	endfunction

	// Driver: presents queued words and records each one the block takes.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				track_word(current_word);
				words_accepted++;
			end
			if (!start || !busy) begin
				if (pending_words.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
					current_word = pending_words.pop_front();
					start        <= 1'b1;
					kind         <= current_word.kind;
					sample_red   <= current_word.red;
					sample_green <= current_word.green;
					sample_blue  <= current_word.blue;
					frame_end    <= current_word.frame_end;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: each strobed pixel is checked against the oldest prediction.
	always @(posedge clk) begin
		pixel_t p;
		if (arst_n && strobe) begin
			if (expected_pixels.size() == 0) begin
				$error("unexpected pixel r=%0d g=%0d b=%0d", pixel_red, pixel_green, pixel_blue);
				error_count++;
			end else begin
				p = expected_pixels.pop_front();
				pixels_checked++;
				if (pixel_red !== p.red) begin
					$error("pixel_red: expected %0d, got %0d", p.red, pixel_red);
					error_count++;
				end
				if (pixel_green !== p.green) begin
					$error("pixel_green: expected %0d, got %0d", p.green, pixel_green);
					error_count++;
				end
				if (pixel_blue !== p.blue) begin
					$error("pixel_blue: expected %0d, got %0d", p.blue, pixel_blue);
					error_count++;
				end
				if (final_pixel !== p.last) begin
					$error("final_pixel: expected %0d, got %0d", p.last, final_pixel);
					error_count++;
				end
			end
		end
	end

	// Watchdog on cycles where no word, pixel or register write moves.
	always @(posedge clk) begin
		if ((start && !busy) || strobe || (cfg_valid && cfg_ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: %0d pixels still expected", expected_pixels.size());
			$display("** minmax_contrast_stretch_rgb: FAILED **");
			$finish;
		end
	end

	function automatic void queue_word(input logic k, input logic signed [SAMPLE_W-1:0] r,
			input logic signed [SAMPLE_W-1:0] g, input logic signed [SAMPLE_W-1:0] b,
			input logic fe);
		word_t w;
		w.kind      = k;
		w.red       = r;
		w.green     = g;
		w.blue      = b;
		w.frame_end = fe;
		pending_words.push_back(w);
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_sample(input int style,
			input logic signed [SAMPLE_W-1:0] base);
		case (style)
			0: return SAMPLE_W'($urandom);
			1: return base + SAMPLE_W'($urandom_range(40));
			2: return base;
			default: return ($urandom_range(1)) ? SAMPLE_TOP : SAMPLE_BOT;
		endcase
	endfunction

	// One frame of loads, the last marked when the frame is closed, followed by some emits.
	function automatic void queue_frame(input int n_load, input int n_emit, input bit closed);
		int                         style [3];
		logic signed [SAMPLE_W-1:0] base [3];
		logic signed [SAMPLE_W-1:0] v [3];
		for (int b = 0; b < 3; b++) begin
			style[b] = $urandom_range(3);
			base[b]  = SAMPLE_W'($urandom);
		end
		for (int i = 0; i < n_load; i++) begin
			for (int b = 0; b < 3; b++)
				v[b] = pick_sample(style[b], base[b]);
			queue_word(KIND_LOAD, v[0], v[1], v[2], closed && i == n_load - 1);
		end
		for (int i = 0; i < n_emit; i++)
			queue_word(KIND_EMIT, SAMPLE_W'($urandom), SAMPLE_W'($urandom),
				SAMPLE_W'($urandom), $urandom_range(1));
	endfunction

	task automatic wait_idle();
		while (pending_words.size() > 0 || start || expected_pixels.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic index, input int unsigned value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= CNT_W'(value);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (index == CFG_TRANSPOSE)
			mode_transpose = value[0];
		else
			mode_columns = value & 13'h1FFF;
	endtask

	// Stimulus: directed words, then phases of random frames under different settings.
	initial begin
		int idle_plan [5]      = '{0, 72, 0, 28, 50};
		int transpose_plan [5] = '{0, 1, 1, 1, 1};
		int columns_plan [5]   = '{5, 1, 3, 0, 4096};
		int phase_start;
		int cols;
		int rows;
		int n;

		arst_n       = 1'b0;
		start        = 1'b0;
		kind         = KIND_LOAD;
		sample_red   = '0;
		sample_green = '0;
		sample_blue  = '0;
		frame_end    = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = CFG_TRANSPOSE;
		cfg_data     = '0;
		error_count  = 0;
		words_accepted = 0;
		pixels_checked = 0;
		quiet_cycles   = 0;
		sender_idle_pct = 0;
		restart_frame();
		mode_transpose = 0;
		mode_columns   = COLS_RESET;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: emit with no frame, extremes, a flat band, wrap past the last pixel.
		queue_word(KIND_EMIT, '0, '0, '0, 1'b0);
		queue_word(KIND_LOAD, SAMPLE_BOT, SAMPLE_TOP, 16'sd7, 1'b0);
		queue_word(KIND_LOAD, SAMPLE_TOP, SAMPLE_BOT, 16'sd7, 1'b0);
		queue_word(KIND_LOAD, -16'sd1, 16'sd0, 16'sd7, 1'b0);
		queue_word(KIND_LOAD, 16'sd0, -16'sd1, 16'sd7, 1'b1);
		repeat (6) queue_word(KIND_EMIT, '0, '0, '0, 1'b0);
		// A load after a closed frame starts afresh; emits before it closes give nothing.
		queue_word(KIND_LOAD, 16'sd100, 16'sd5, -16'sd9, 1'b0);
		queue_word(KIND_EMIT, '1, '1, '1, 1'b1);
		queue_word(KIND_LOAD, 16'sd200, 16'sd5, 16'sd9, 1'b1);
		repeat (3) queue_word(KIND_EMIT, '0, '0, '0, 1'b0);
		wait_idle();

		for (int ph = 0; ph < 5; ph++) begin
			write_register(CFG_TRANSPOSE, transpose_plan[ph]);
			write_register(CFG_COLUMNS, columns_plan[ph]);
			sender_idle_pct = idle_plan[ph];
			cols = (columns_plan[ph] >= 1 && columns_plan[ph] <= 8) ? columns_plan[ph] : 0;
			phase_start = words_accepted + pending_words.size();
			while (words_accepted + pending_words.size() - phase_start < 160) begin
				rows = $urandom_range(1, 6);
				if (cols != 0 && $urandom_range(3) != 0)
					n = rows * cols;
				else
					n = $urandom_range(1, 12);
				if ($urandom_range(9) == 0)
					queue_frame(n, $urandom_range(1, 4), 0);
				else
					queue_frame(n, n + $urandom_range(0, n), 1);
			end
			wait_idle();
		end

		$display("covered %0d accepted words and %0d checked pixels", words_accepted,
			pixels_checked);
		$display("over five register settings, with row-major and transposed frames");
		if (error_count == 0)
			$display("** minmax_contrast_stretch_rgb: PASSED **");
		else
			$display("** minmax_contrast_stretch_rgb: FAILED **");
		$finish;
	end

endmodule

@@ filelist.f @@
src/mcs_pkg.sv
src/mcs_div.sv
src/mcs_dp.sv
src/mcs_ctrl.sv
src/minmax_contrast_stretch_rgb.sv
src/mcs_chk.sv
tb/sv/minmax_contrast_stretch_rgb_tb.sv
